@@ hdl/rpse_pkg.sv @@
// ----------------------------------------------------------------------------
// rpse_pkg
// shared widths, register codes and types of the ridge peak spacing estimator
// ----------------------------------------------------------------------------
package rpse_pkg;

  localparam int unsigned SigMax   = 64;
  localparam int unsigned PosW     = $clog2(SigMax);
  localparam int unsigned SampleW  = 16;
  localparam int unsigned SpcW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned AvgW     = 14;
  localparam int unsigned FreqW    = 16;
  localparam int unsigned AvgShift = 9;
  localparam int unsigned FrqShift = 17;
  localparam int unsigned CmpW     = (PosW > SpcW) ? PosW : SpcW;
  localparam int unsigned MulW     = SpcW + CntW;

  localparam int unsigned DivW     = CntW + FrqShift;
  localparam int unsigned DivisorW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgLevel   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpacing = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinDist = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxDist = 2'd3;

  localparam logic [SampleW-1:0] LevelRst   = 16'd16384;
  localparam logic [SpcW-1:0]    SpacingRst = 6'd6;
  localparam logic [SpcW-1:0]    MinDistRst = 6'd3;
  localparam logic [SpcW-1:0]    MaxDistRst = 6'd25;

  typedef struct packed {
    logic [SampleW-1:0] level;
    logic [SpcW-1:0]    spacing;
    logic [SpcW-1:0]    min_dist;
    logic [SpcW-1:0]    max_dist;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [PosW-1:0] span;
    logic            pre_ok;
  } win_t;

endpackage

@@ hdl/ridge_peak_spacing_estimator_core.sv @@
// ----------------------------------------------------------------------------
// ridge_peak_spacing_estimator_core
// peak spacing and frequency estimate over a signature window
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  sample_i, window_end_i
//   out       source     out_valid_o/out_stall_i average_spacing_o, frequency_o,
//                                               spacing_valid_o, peak_total_o
//   cfg       sink       cfg_we_i               cfg_index_i, cfg_data_i
//
// one sample per cycle unless stalled; a summary waits in a two-entry queue
// the back end runs the serial divider for each window that passes the bounds check
// (24 quotient bits for the average, then 24 for the frequency)
// in_stall_o rises only while the queue holds two unfinished windows
// reset clears front-end and control state and loads register defaults at once
// ----------------------------------------------------------------------------
module ridge_peak_spacing_estimator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rpse_pkg::SampleW-1:0]   sample_i,
  input  logic                           window_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rpse_pkg::AvgW-1:0]      average_spacing_o,
  output logic [rpse_pkg::FreqW-1:0]     frequency_o,
  output logic                           spacing_valid_o,
  output logic [rpse_pkg::CntW-1:0]      peak_total_o,
  input  logic                           cfg_we_i,
  input  logic [rpse_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpse_pkg::CfgDataW-1:0]  cfg_data_i
);

  rpse_pkg::cfg_t cfg_q, cfg_d;
  rpse_pkg::win_t win_push;
  rpse_pkg::win_t win_head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        rpse_pkg::CfgLevel:   cfg_d.level    = cfg_data_i;
        rpse_pkg::CfgSpacing: cfg_d.spacing  = cfg_data_i[rpse_pkg::SpcW-1:0];
        rpse_pkg::CfgMinDist: cfg_d.min_dist = cfg_data_i[rpse_pkg::SpcW-1:0];
        rpse_pkg::CfgMaxDist: cfg_d.max_dist = cfg_data_i[rpse_pkg::SpcW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level    <= rpse_pkg::LevelRst;
      cfg_q.spacing  <= rpse_pkg::SpacingRst;
      cfg_q.min_dist <= rpse_pkg::MinDistRst;
      cfg_q.max_dist <= rpse_pkg::MaxDistRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rpse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .window_end_i (window_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .win_o        (win_push)
  );

  rpse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (win_push),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (win_head)
  );

  rpse_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .q_data_i          (win_head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .average_spacing_o (average_spacing_o),
    .frequency_o       (frequency_o),
    .spacing_valid_o   (spacing_valid_o),
    .peak_total_o      (peak_total_o)
  );

endmodule

@@ hdl/rpse_front.sv @@
// ----------------------------------------------------------------------------
// rpse_front
// sample intake, peak candidate detection and merging, one window summary out
// ----------------------------------------------------------------------------
module rpse_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpse_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rpse_pkg::SampleW-1:0]  sample_i,
  input  logic                          window_end_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output rpse_pkg::win_t                win_o
);

  typedef struct packed {
    logic [rpse_pkg::PosW-1:0]    kpos;
    logic [rpse_pkg::SampleW-1:0] klvl;
    logic [rpse_pkg::PosW-1:0]    fpos;
    logic [rpse_pkg::CntW-1:0]    cnt;
  } peak_t;

  function automatic peak_t offer(peak_t st, logic [rpse_pkg::PosW-1:0] pos,
                                  logic [rpse_pkg::SampleW-1:0] lvl,
                                  logic [rpse_pkg::SpcW-1:0] msp);
    peak_t                     r;
    logic [rpse_pkg::PosW-1:0] gap;
    r   = st;
    gap = pos - st.kpos;
    if (st.cnt == '0) begin
      r.fpos = pos;
      r.kpos = pos;
      r.klvl = lvl;
      r.cnt  = rpse_pkg::CntW'(1);
    end else if (rpse_pkg::CmpW'(gap) > rpse_pkg::CmpW'(msp)) begin
      r.kpos = pos;
      r.klvl = lvl;
      if (st.cnt != '1) begin
        r.cnt = st.cnt + 1'b1;
      end
    end else if (lvl > st.klvl) begin
      r.kpos = pos;
      r.klvl = lvl;
      if (st.cnt == rpse_pkg::CntW'(1)) begin
        r.fpos = pos;
      end
    end
    return r;
  endfunction

  logic [rpse_pkg::SampleW-1:0] older_q, older_d;
  logic [rpse_pkg::SampleW-1:0] newer_q, newer_d;
  logic [rpse_pkg::PosW-1:0]    pos_q, pos_d;
  peak_t                        peak_q, peak_d;

  logic  accept;
  logic  last;
  logic  left_ok;
  logic  cand_left;
  logic  cand_end;
  peak_t st_left;
  peak_t st_end;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    last      = window_end_i || (pos_q >= rpse_pkg::PosW'(rpse_pkg::SigMax - 1));
    left_ok   = (pos_q == rpse_pkg::PosW'(1)) || (older_q <= newer_q);
    cand_left = (pos_q != '0) && (newer_q > cfg_i.level) && left_ok &&
                (newer_q >= sample_i);
    cand_end  = last && (sample_i > cfg_i.level) &&
                ((pos_q == '0) || (sample_i >= newer_q));
    st_left   = cand_left ? offer(peak_q, pos_q - rpse_pkg::PosW'(1), newer_q,
                                  cfg_i.spacing) : peak_q;
    st_end    = cand_end ? offer(st_left, pos_q, sample_i, cfg_i.spacing) : st_left;

    win_o.count  = st_end.cnt;
    win_o.span   = st_end.kpos - st_end.fpos;
    win_o.pre_ok = (st_end.cnt >= rpse_pkg::CntW'(2)) && (st_end.kpos > st_end.fpos);
    push_o       = accept && last;

    older_d = older_q;
    newer_d = newer_q;
    pos_d   = pos_q;
    peak_d  = peak_q;
    if (accept) begin
      if (last) begin
        older_d = '0;
        newer_d = '0;
        pos_d   = '0;
        peak_d  = '0;
      end else begin
        older_d = newer_q;
        newer_d = sample_i;
        pos_d   = pos_q + 1'b1;
        peak_d  = st_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      pos_q   <= '0;
      peak_q  <= '0;
    end else begin
      older_q <= older_d;
      newer_q <= newer_d;
      pos_q   <= pos_d;
      peak_q  <= peak_d;
    end
  end

endmodule

@@ hdl/rpse_queue.sv @@
// ----------------------------------------------------------------------------
// rpse_queue
// two-entry queue of window summaries between front and back
// ----------------------------------------------------------------------------
module rpse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpse_pkg::win_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rpse_pkg::win_t data_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned FillW  = $clog2(QDepth + 1);

  rpse_pkg::win_t    slot_q [QDepth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [FillW-1:0]  fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(QDepth));
  assign valid_o = (fill_q != '0);
  assign data_o  = slot_q[rd_q];

  always_comb begin
    wr_d   = push_i ? wr_q + 1'b1 : wr_q;
    rd_d   = pop_i ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");

endmodule

@@ hdl/rpse_div.sv @@
// ----------------------------------------------------------------------------
// rpse_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rpse_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rpse_pkg::DivW-1:0]      dividend_i,
  input  logic [rpse_pkg::DivisorW-1:0]  divisor_i,
  output logic                           done_o,
  output logic [rpse_pkg::DivW-1:0]      quotient_o
);

  logic [rpse_pkg::DivW-1:0]     dvd_q;
  logic [rpse_pkg::DivisorW-1:0] dvs_q;
  logic [rpse_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [rpse_pkg::DivCntW-1:0]  cnt_q;
  logic                          done_q;
  logic [rpse_pkg::DivisorW:0]   trial;
  logic                          qbit;

  always_comb begin
    trial = {rem_q, dvd_q[rpse_pkg::DivW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? rpse_pkg::DivisorW'(trial - {1'b0, dvs_q})
                 : trial[rpse_pkg::DivisorW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= rpse_pkg::DivCntW'(rpse_pkg::DivSteps);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == rpse_pkg::DivCntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[rpse_pkg::DivW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ hdl/rpse_back.sv @@
// ----------------------------------------------------------------------------
// rpse_back
// bounds check, average spacing and frequency division, result register
// ----------------------------------------------------------------------------
module rpse_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpse_pkg::cfg_t                cfg_i,
  input  logic                          q_valid_i,
  input  rpse_pkg::win_t                q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rpse_pkg::AvgW-1:0]     average_spacing_o,
  output logic [rpse_pkg::FreqW-1:0]    frequency_o,
  output logic                          spacing_valid_o,
  output logic [rpse_pkg::CntW-1:0]     peak_total_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SAvg   = 3'd2;
  localparam logic [2:0] SFreq  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [rpse_pkg::CntW-1:0]    count_q;
  logic [rpse_pkg::CntW-1:0]    n1_q;
  logic [rpse_pkg::PosW-1:0]    span_q;
  logic                         pre_q;
  logic                         ok_q;
  logic [rpse_pkg::AvgW-1:0]    avg_q;
  logic [rpse_pkg::FreqW-1:0]   freq_q;

  logic                         out_valid_q, out_valid_d;
  logic [rpse_pkg::AvgW-1:0]    out_avg_q;
  logic [rpse_pkg::FreqW-1:0]   out_freq_q;
  logic                         out_ok_q;
  logic [rpse_pkg::CntW-1:0]    out_total_q;

  logic [rpse_pkg::MulW-1:0]    lo;
  logic [rpse_pkg::MulW-1:0]    hi;
  logic                         ok;
  logic                         load;
  logic                         div_start;
  logic                         div_done;
  logic [rpse_pkg::DivW-1:0]    div_dividend;
  logic [rpse_pkg::DivisorW-1:0] div_divisor;
  logic [rpse_pkg::DivW-1:0]    div_quo;
  logic [rpse_pkg::AvgW-1:0]    avg_sat;
  logic [rpse_pkg::FreqW-1:0]   freq_sat;

  rpse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    lo  = rpse_pkg::MulW'(cfg_i.min_dist) * rpse_pkg::MulW'(n1_q);
    hi  = rpse_pkg::MulW'(cfg_i.max_dist) * rpse_pkg::MulW'(n1_q);
    ok  = pre_q && (rpse_pkg::MulW'(span_q) >= lo) && (rpse_pkg::MulW'(span_q) <= hi);

    avg_sat  = (|div_quo[rpse_pkg::DivW-1:rpse_pkg::AvgW]) ? '1
             : div_quo[rpse_pkg::AvgW-1:0];
    freq_sat = (|div_quo[rpse_pkg::DivW-1:rpse_pkg::FreqW]) ? '1
             : div_quo[rpse_pkg::FreqW-1:0];

    if (state_q == SCheck) begin
      div_dividend = (rpse_pkg::DivW'(span_q) << rpse_pkg::AvgShift) +
                     rpse_pkg::DivW'(n1_q);
      div_divisor  = rpse_pkg::DivisorW'({n1_q, 1'b0});
    end else begin
      div_dividend = (rpse_pkg::DivW'(n1_q) << rpse_pkg::FrqShift) +
                     rpse_pkg::DivW'(span_q);
      div_divisor  = rpse_pkg::DivisorW'({span_q, 1'b0});
    end

    pop_o     = (state_q == SIdle) && q_valid_i;
    div_start = ((state_q == SCheck) && ok) || ((state_q == SAvg) && div_done);
    load      = (state_q == SDone) && (!out_valid_q || !out_stall_i);

    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        state_d = ok ? SAvg : SDone;
      end
      SAvg: begin
        if (div_done) begin
          state_d = SFreq;
        end
      end
      SFreq: begin
        if (div_done) begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      count_q <= q_data_i.count;
      n1_q    <= q_data_i.count - 1'b1;
      span_q  <= q_data_i.span;
      pre_q   <= q_data_i.pre_ok;
    end
    if (state_q == SCheck) begin
      ok_q   <= ok;
      avg_q  <= '0;
      freq_q <= '0;
    end
    if ((state_q == SAvg) && div_done) begin
      avg_q <= avg_sat;
    end
    if ((state_q == SFreq) && div_done) begin
      freq_q <= freq_sat;
    end
    if (load) begin
      out_avg_q   <= avg_q;
      out_freq_q  <= freq_q;
      out_ok_q    <= ok_q;
      out_total_q <= count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_spacing_o = out_avg_q;
  assign frequency_o       = out_freq_q;
  assign spacing_valid_o   = out_ok_q;
  assign peak_total_o      = out_total_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !spacing_valid_o) |-> (average_spacing_o == '0 && frequency_o == '0))
    else $error("invalid result carries nonzero fields");

  a_valid_two_peaks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && spacing_valid_o) |-> (peak_total_o >= rpse_pkg::CntW'(2)))
    else $error("valid spacing with fewer than two peaks");

endmodule
